### src/ttint_pkg.sv
// Shared constants, codes and types of the trajectory table interpolator.
`timescale 1ns / 1ps
`default_nettype none
package ttint_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int DATA_W = 32;
  localparam int TOL_W  = 31;

  // Request modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_TIME  = 2'd1;
  localparam logic [1:0] MODE_PROG  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_QUERY = 2'd1;
  localparam logic [1:0] ST_BAD_TABLE = 2'd2;
  localparam logic [1:0] ST_NO_SEG    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_ORIGIN = 2'd0;
  localparam logic [1:0] CFG_TOL    = 2'd1;
  localparam logic [1:0] CFG_COUNT  = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] tm;
    logic signed [DATA_W-1:0] path;
    logic signed [DATA_W-1:0] prog;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_T_ADDR,
    S_T_CHK,
    S_T_WAIT,
    S_P_ADDR,
    S_P_CHK,
    S_P_WAIT,
    S_P_UPD,
    S_P_NEXT
  } state_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_MUL,
    D_DIV
  } div_state_t;

endpackage
`default_nettype wire

### src/ttint_muldiv.sv
// Shared scale unit: floor(num * dy / den), one multiply then one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module ttint_muldiv (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [ttint_pkg::DATA_W-1:0] num,
  input  wire logic [ttint_pkg::DATA_W-1:0] dy,
  input  wire logic [ttint_pkg::DATA_W-1:0] den,
  output logic                              done,
  output logic      [ttint_pkg::DATA_W-1:0] quot
);
  import ttint_pkg::*;

  localparam int STEP_W = $clog2(DATA_W);

  div_state_t          state_r, state_nxt;
  logic [DATA_W-1:0]   a_r, a_nxt, b_r, b_nxt, den_r, den_nxt;
  logic [DATA_W-1:0]   rem_r, rem_nxt, low_r, low_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic                done_r, done_nxt;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W:0]     trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    cnt_r <= cnt_nxt;
  end

  // Multiply once, then restoring division with quotient shifted into low_r
  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    a_nxt     = a_r;
    b_nxt     = b_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    low_nxt   = low_r;
    cnt_nxt   = cnt_r;
    prod      = a_r * b_r;
    trial     = {rem_r, low_r[DATA_W-1]};
    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          a_nxt     = num;
          b_nxt     = dy;
          den_nxt   = den;
          state_nxt = D_MUL;
        end
      end
      D_MUL: begin
        rem_nxt   = prod[2*DATA_W-1:DATA_W];
        low_nxt   = prod[DATA_W-1:0];
        cnt_nxt   = '1;
        state_nxt = D_DIV;
      end
      D_DIV: begin
        if (trial >= {1'b0, den_r}) begin
          rem_nxt = DATA_W'(trial - {1'b0, den_r});
          low_nxt = {low_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DATA_W-1:0];
          low_nxt = {low_r[DATA_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  assign done = done_r;
  assign quot = (den_r == '0) ? '0 : low_r;

endmodule
`default_nettype wire

### src/trajectory_table_interpolator.sv
// Top level: table memory, configuration registers and query sequencer.
// A load or an unused mode gives its result in the cycle after start. A time
// query scans the entries in order and, on finding one at or above the query
// time, runs the shared multiply-divide unit; a progress query checks the
// entries in turn and runs the unit for each matching sloped segment. One item
// at a time: busy stays high until the result strobe. Synchronous reset clears
// control and configuration; table contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module trajectory_table_interpolator (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          in_mode,
  input  wire logic [ttint_pkg::IDX_W-1:0]         in_entry_index,
  input  wire logic signed [ttint_pkg::DATA_W-1:0] in_entry_time,
  input  wire logic signed [ttint_pkg::DATA_W-1:0] in_entry_path,
  input  wire logic signed [ttint_pkg::DATA_W-1:0] in_entry_progress,
  input  wire logic signed [ttint_pkg::DATA_W-1:0] in_query_time,
  input  wire logic signed [ttint_pkg::DATA_W-1:0] in_query_progress,
  input  wire logic signed [ttint_pkg::DATA_W-1:0] in_cursor_path,
  output logic                                     out_valid,
  output logic signed [ttint_pkg::DATA_W-1:0]      out_path_distance,
  output logic [1:0]                               out_status,
  input  wire logic                                cfg_we,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [ttint_pkg::DATA_W-1:0]        cfg_wdata
);
  import ttint_pkg::*;

  // Configuration
  logic signed [DATA_W-1:0] origin_r;
  logic [TOL_W-1:0]         tol_r;
  logic [CNT_W-1:0]         count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      tol_r    <= '0;
      count_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN: origin_r <= cfg_wdata;
        CFG_TOL:    tol_r    <= cfg_wdata[TOL_W-1:0];
        CFG_COUNT:  count_r  <= cfg_wdata[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Table memory, one entry wide, registered read
  entry_t            mem [DEPTH];
  entry_t            rd_q;
  logic              mem_we;
  logic [IDX_W-1:0]  rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_entry_index] <= '{tm: in_entry_time, path: in_entry_path,
                               prog: in_entry_progress};
    end
    rd_q <= mem[rd_addr];
  end

  // Shared scale unit
  logic              div_start, div_done;
  logic [DATA_W-1:0] div_num, div_dy, div_den, div_q;

  ttint_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .dy    (div_dy),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  // Sequencer registers
  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic signed [DATA_W-1:0] qv_r, qv_nxt, cur_r, cur_nxt;
  logic signed [DATA_W-1:0] prev_a_r, prev_a_nxt, prev_path_r, prev_path_nxt;
  logic signed [DATA_W-1:0] base_r, base_nxt, cand_r, cand_nxt, best_r, best_nxt;
  logic [DATA_W:0]          best_err_r, best_err_nxt;
  logic                     found_r, found_nxt;
  logic                     outv_r, outv_nxt;
  logic signed [DATA_W-1:0] outp_r, outp_nxt;
  logic [1:0]               outs_r, outs_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      outv_r  <= outv_nxt;
    end
    idx_r       <= idx_nxt;
    qv_r        <= qv_nxt;
    cur_r       <= cur_nxt;
    prev_a_r    <= prev_a_nxt;
    prev_path_r <= prev_path_nxt;
    base_r      <= base_nxt;
    cand_r      <= cand_nxt;
    best_r      <= best_nxt;
    best_err_r  <= best_err_nxt;
    found_r     <= found_nxt;
    outp_r      <= outp_nxt;
    outs_r      <= outs_nxt;
  end

  logic                     bad_count, last, better, reg_bad, path_bad, in_seg;
  logic signed [DATA_W+1:0] prog_tol;
  logic signed [DATA_W-1:0] lo, hi;
  logic signed [DATA_W:0]   err_diff;
  logic [DATA_W:0]          err;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    qv_nxt        = qv_r;
    cur_nxt       = cur_r;
    prev_a_nxt    = prev_a_r;
    prev_path_nxt = prev_path_r;
    base_nxt      = base_r;
    cand_nxt      = cand_r;
    best_nxt      = best_r;
    best_err_nxt  = best_err_r;
    found_nxt     = found_r;
    outv_nxt      = 1'b0;
    outp_nxt      = outp_r;
    outs_nxt      = outs_r;
    mem_we        = 1'b0;
    rd_addr       = idx_r[IDX_W-1:0];
    div_start     = 1'b0;
    div_num       = '0;
    div_dy        = '0;
    div_den       = '0;

    bad_count = (count_r == '0) || (count_r > CNT_W'(DEPTH));
    last      = ((idx_r + 1'b1) == count_r);
    prog_tol  = (DATA_W+2)'(rd_q.prog) + $signed({3'b000, tol_r});
    reg_bad   = prog_tol < (DATA_W+2)'(prev_a_r);
    path_bad  = (idx_r == '0) ? (rd_q.path < 0) : (rd_q.path <= prev_path_r);
    lo        = (rd_q.prog < prev_a_r) ? rd_q.prog : prev_a_r;
    hi        = (rd_q.prog < prev_a_r) ? prev_a_r : rd_q.prog;
    in_seg    = (qv_r >= lo) && (qv_r <= hi);
    err_diff  = (DATA_W+1)'(cand_r) - (DATA_W+1)'(cur_r);
    err       = err_diff[DATA_W] ? $unsigned(-err_diff) : $unsigned(err_diff);
    better    = !found_r || (err < best_err_r);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_mode)
            MODE_LOAD: begin
              mem_we   = 1'b1;
              outv_nxt = 1'b1;
              outp_nxt = '0;
              outs_nxt = ST_OK;
            end
            MODE_TIME: begin
              qv_nxt  = in_query_time;
              idx_nxt = '0;
              if (in_query_time < 0) begin
                outv_nxt = 1'b1;
                outp_nxt = '0;
                outs_nxt = ST_BAD_QUERY;
              end else if (bad_count) begin
                outv_nxt = 1'b1;
                outp_nxt = '0;
                outs_nxt = ST_BAD_TABLE;
              end else begin
                state_nxt = S_T_ADDR;
              end
            end
            MODE_PROG: begin
              qv_nxt        = in_query_progress;
              cur_nxt       = in_cursor_path;
              idx_nxt       = '0;
              prev_a_nxt    = origin_r;
              prev_path_nxt = '0;
              found_nxt     = 1'b0;
              best_err_nxt  = '0;
              best_nxt      = '0;
              if (in_cursor_path < 0) begin
                outv_nxt = 1'b1;
                outp_nxt = '0;
                outs_nxt = ST_BAD_QUERY;
              end else if (bad_count) begin
                outv_nxt = 1'b1;
                outp_nxt = '0;
                outs_nxt = ST_BAD_TABLE;
              end else begin
                state_nxt = S_P_ADDR;
              end
            end
            default: begin
              outv_nxt = 1'b1;
              outp_nxt = '0;
              outs_nxt = ST_BAD_QUERY;
            end
          endcase
        end
      end

      // Time query: scan for the first entry at or above the query time
      S_T_ADDR: state_nxt = S_T_CHK;
      S_T_CHK: begin
        if (rd_q.tm >= qv_r) begin
          if (idx_r == '0) begin
            if (rd_q.tm <= 0 || rd_q.path < 0) begin
              outv_nxt  = 1'b1;
              outp_nxt  = '0;
              outs_nxt  = ST_BAD_TABLE;
              state_nxt = S_IDLE;
            end else begin
              div_start = 1'b1;
              div_num   = qv_r;
              div_dy    = rd_q.path;
              div_den   = rd_q.tm;
              base_nxt  = '0;
              state_nxt = S_T_WAIT;
            end
          end else if (rd_q.tm <= prev_a_r || rd_q.path <= prev_path_r) begin
            outv_nxt  = 1'b1;
            outp_nxt  = '0;
            outs_nxt  = ST_BAD_TABLE;
            state_nxt = S_IDLE;
          end else begin
            div_start = 1'b1;
            div_num   = $unsigned(qv_r) - $unsigned(prev_a_r);
            div_dy    = $unsigned(rd_q.path) - $unsigned(prev_path_r);
            div_den   = $unsigned(rd_q.tm) - $unsigned(prev_a_r);
            base_nxt  = prev_path_r;
            state_nxt = S_T_WAIT;
          end
        end else begin
          prev_a_nxt    = rd_q.tm;
          prev_path_nxt = rd_q.path;
          if (last) begin
            outv_nxt  = 1'b1;
            outp_nxt  = rd_q.path;
            outs_nxt  = ST_OK;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_T_ADDR;
          end
        end
      end
      S_T_WAIT: begin
        if (div_done) begin
          outv_nxt  = 1'b1;
          outp_nxt  = base_r + $signed(div_q);
          outs_nxt  = ST_OK;
          state_nxt = S_IDLE;
        end
      end

      // Progress query: check each segment, project the target where it lies
      S_P_ADDR: state_nxt = S_P_CHK;
      S_P_CHK: begin
        if (path_bad || reg_bad) begin
          outv_nxt  = 1'b1;
          outp_nxt  = '0;
          outs_nxt  = ST_BAD_TABLE;
          state_nxt = S_IDLE;
        end else begin
          prev_a_nxt    = rd_q.prog;
          prev_path_nxt = rd_q.path;
          base_nxt      = prev_path_r;
          div_dy        = $unsigned(rd_q.path) - $unsigned(prev_path_r);
          if (!in_seg) begin
            state_nxt = S_P_NEXT;
          end else if (rd_q.prog == prev_a_r) begin
            // Flat segment: clamp the cursor into the path range
            if (cur_r < prev_path_r) cand_nxt = prev_path_r;
            else if (cur_r > rd_q.path) cand_nxt = rd_q.path;
            else cand_nxt = cur_r;
            state_nxt = S_P_UPD;
          end else if (rd_q.prog > prev_a_r) begin
            div_start = 1'b1;
            div_num   = $unsigned(qv_r) - $unsigned(prev_a_r);
            div_den   = $unsigned(rd_q.prog) - $unsigned(prev_a_r);
            state_nxt = S_P_WAIT;
          end else begin
            div_start = 1'b1;
            div_num   = $unsigned(prev_a_r) - $unsigned(qv_r);
            div_den   = $unsigned(prev_a_r) - $unsigned(rd_q.prog);
            state_nxt = S_P_WAIT;
          end
        end
      end
      S_P_WAIT: begin
        if (div_done) begin
          cand_nxt  = base_r + $signed(div_q);
          state_nxt = S_P_UPD;
        end
      end
      S_P_UPD, S_P_NEXT: begin
        // Keep the nearest candidate; the first one wins a tie
        if (state_r == S_P_UPD && better) begin
          best_nxt     = cand_r;
          best_err_nxt = err;
          found_nxt    = 1'b1;
        end
        if (last) begin
          outv_nxt  = 1'b1;
          state_nxt = S_IDLE;
          if (found_nxt) begin
            outp_nxt = best_nxt;
            outs_nxt = ST_OK;
          end else begin
            outp_nxt = '0;
            outs_nxt = ST_NO_SEG;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_P_ADDR;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = outv_r;
  assign out_path_distance = outp_r;
  assign out_status        = outs_r;

endmodule
`default_nettype wire

### src/ttint_chk.sv
// Port-level checker for the trajectory table interpolator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ttint_chk (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                start,
  input wire logic                                busy,
  input wire logic [1:0]                          in_mode,
  input wire logic signed [ttint_pkg::DATA_W-1:0] in_query_time,
  input wire logic                                out_valid,
  input wire logic signed [ttint_pkg::DATA_W-1:0] out_path_distance,
  input wire logic [1:0]                          out_status
);
  import ttint_pkg::*;

  // A failed beat carries a zero distance
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_path_distance == '0)
    else $error("non-zero distance with failing status");

  // A result beat leaves the block idle
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  // A load answers next cycle with ok and zero
  a_load_reply: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode == MODE_LOAD |=>
      out_valid && out_status == ST_OK && out_path_distance == '0)
    else $error("load reply wrong");

  // A negative time query is rejected at once
  a_neg_time: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode == MODE_TIME && in_query_time < 0 |=>
      out_valid && out_status == ST_BAD_QUERY)
    else $error("negative time not rejected");

  // The unused mode is rejected at once
  a_bad_mode: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode != MODE_LOAD && in_mode != MODE_TIME &&
      in_mode != MODE_PROG |=> out_valid && out_status == ST_BAD_QUERY)
    else $error("unused mode not rejected");

endmodule

bind trajectory_table_interpolator ttint_chk u_ttint_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_mode           (in_mode),
  .in_query_time     (in_query_time),
  .out_valid         (out_valid),
  .out_path_distance (out_path_distance),
  .out_status        (out_status)
);
`default_nettype wire
